### src/ctp_pkg.sv
package ctp_pkg;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] RADIX = 8'd10;
	localparam logic [7:0] MAX_ENTRIES_RST = 8'd255;

	typedef struct packed {
		logic [7:0] run_count;
		logic [7:0] entries_done;
		logic       limit_hit;
	} ctp_state_t;

	typedef struct packed {
		logic       has_entry;
		logic [7:0] op_count;
		logic [7:0] op_type;
		logic [7:0] entry_index;
		logic       done_res;
		logic [7:0] total_entries;
	} ctp_res_t;

endpackage

### src/ctp_if.sv
interface ctp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
endinterface

interface ctp_entry_if;
	logic       valid;
	logic       ready;
	logic       has_entry;
	logic [7:0] op_count;
	logic [7:0] op_type;
	logic [7:0] entry_index;
	logic       done_res;
	logic [7:0] total_entries;

	modport source (output valid, has_entry, op_count, op_type, entry_index, done_res,
		total_entries, input ready);
	modport sink (input valid, has_entry, op_count, op_type, entry_index, done_res,
		total_entries, output ready);
endinterface

interface ctp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/ctp_step.sv
module ctp_step (
	input  ctp_pkg::ctp_state_t state,
	input  logic [7:0]          ch,
	input  logic                last,
	input  logic [7:0]          max_entries,
	output ctp_pkg::ctp_state_t state_nxt,
	output ctp_pkg::ctp_res_t   res,
	output logic                produce
);
	import ctp_pkg::*;

	ctp_state_t upd;
	logic       emit;
	logic       is_digit;
	logic [7:0] digit;
	logic [7:0] done_inc;

	always_comb begin
		upd = state;
		emit = 1'b0;
		is_digit = ch inside {[CH_ZERO:CH_NINE]};
		digit = ch - CH_ZERO;
		done_inc = state.entries_done + 8'd1;
		if (!state.limit_hit) begin
			if (is_digit) begin
				upd.run_count = state.run_count * RADIX + digit;
			end else if (state.run_count != 8'd0) begin
				emit = 1'b1;
				upd.run_count = 8'd0;
				upd.entries_done = done_inc;
				if (done_inc >= max_entries) begin
					upd.limit_hit = 1'b1;
				end
			end
		end

		res.has_entry = emit;
		res.op_count = emit ? state.run_count : 8'd0;
		res.op_type = emit ? ch : 8'd0;
		res.entry_index = emit ? state.entries_done : 8'd0;
		res.done_res = last;
		res.total_entries = upd.entries_done;
		produce = emit || last;

		// end of string: start the next one from scratch
		if (last) begin
			state_nxt = '0;
		end else begin
			state_nxt = upd;
		end
	end

endmodule

### src/cigar_text_parser.sv
// CIGAR text parser: takes one character per clock on chars (last flags the end of a
// string) unless a character that gives a result waits on a full result register, and
// returns at most one result per character on entries: a completed run (count, op
// letter, index) and/or the done result with the entry total. A character passes the
// character register, the combinational parse step and the result register. max_entries
// is written through cfg and should only change between strings.
module cigar_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	ctp_char_if.sink    chars,
	ctp_entry_if.source entries,
	ctp_cfg_if.sink     cfg
);
	import ctp_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	ctp_state_t state_q;
	ctp_state_t state_nxt;
	ctp_res_t   res;
	ctp_res_t   res_q;
	logic       produce;
	logic       out_valid_q;
	logic       out_free;
	logic       advance_s1;
	logic [7:0] max_entries_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg.valid) begin
			max_entries_q <= cfg.data;
		end
	end

	ctp_step u_step (
		.state       (state_q),
		.ch          (ch_s1),
		.last        (last_s1),
		.max_entries (max_entries_q),
		.state_nxt   (state_nxt),
		.res         (res),
		.produce     (produce)
	);

	assign out_free = !out_valid_q || entries.ready;
	// characters that give no result never wait on the output side
	assign advance_s1 = valid_s1 && (!produce || out_free);
	assign chars.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1 <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance_s1 && produce) begin
			res_q <= res;
		end
	end

	assign entries.valid = out_valid_q;
	assign entries.has_entry = res_q.has_entry;
	assign entries.op_count = res_q.op_count;
	assign entries.op_type = res_q.op_type;
	assign entries.entry_index = res_q.entry_index;
	assign entries.done_res = res_q.done_res;
	assign entries.total_entries = res_q.total_entries;

	a_entry_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.has_entry |-> res_q.op_count != 8'd0)
		else $error("entry with zero run count");

	a_entry_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.has_entry |-> res_q.total_entries == res_q.entry_index + 8'd1)
		else $error("entry total does not follow entry index");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && last_s1 |=> state_q == '0)
		else $error("parse state not cleared after last character");

	a_result_only_when_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.has_entry || res_q.done_res)
		else $error("result without entry or done");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import ctp_pkg::*;

	typedef logic [7:0] char_q_t[$];

	localparam logic [71:0] OP_LETTERS = "MIDNSHP=X";

	class cigar_scoreboard;
		logic [7:0] max_entries;
		logic [7:0] run_count;
		logic [7:0] entries_done;
		logic       limit_hit;
		ctp_res_t   pending_entries[$];
		int         errors;

		function new();
			max_entries = MAX_ENTRIES_RST;
			run_count = '0;
			entries_done = '0;
			limit_hit = 1'b0;
			errors = 0;
		endfunction

		function void note_char(logic [7:0] c, logic fin);
			ctp_res_t r;
			r = '0;
			if (!limit_hit) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					// 8-bit context: wraps modulo 256
					run_count = run_count * RADIX + (c - CH_ZERO);
				end else if (run_count != 0) begin
					r.has_entry = 1'b1;
					r.op_count = run_count;
					r.op_type = c;
					r.entry_index = entries_done;
					entries_done = entries_done + 8'd1;
					run_count = '0;
					if (entries_done >= max_entries)
						limit_hit = 1'b1;
				end
			end
			if (r.has_entry || fin) begin
				r.done_res = fin;
				r.total_entries = entries_done;
				pending_entries.push_back(r);
			end
			if (fin) begin
				run_count = '0;
				entries_done = '0;
				limit_hit = 1'b0;
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ctp_res_t got);
			ctp_res_t want;
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_entries.pop_front();
			compare_field("has_entry", want.has_entry, got.has_entry);
			compare_field("op_count", want.op_count, got.op_count);
			compare_field("op_type", want.op_type, got.op_type);
			compare_field("entry_index", want.entry_index, got.entry_index);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("total_entries", want.total_entries, got.total_entries);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ctp_char_if  chars_if();
	ctp_entry_if ent_if();
	ctp_cfg_if   cfg_if();

	cigar_scoreboard cigar_sb;
	int hold_cycles;
	bit idle_en;
	int sent_items;

	cigar_text_parser i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.entries (ent_if),
		.cfg     (cfg_if)
	);

	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b >= CH_ZERO && b <= CH_NINE);
		return b;
	endfunction

	function automatic logic [7:0] op_letter();
		return OP_LETTERS[8 * $urandom_range(0, 8) +: 8];
	endfunction

	// mostly well-formed strings; some noise, some ending on a dangling count
	function automatic char_q_t random_cigar();
		char_q_t s;
		int kind;
		int cnt;
		string txt;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			repeat ($urandom_range(1, 10))
				s.push_back($urandom_range(0, 1) ? 8'(CH_ZERO + $urandom_range(0, 9))
					: 8'($urandom_range(0, 255)));
			return s;
		end
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
				0: cnt = 0;
				1: cnt = $urandom_range(100, 999);
				default: cnt = $urandom_range(1, 99);
			endcase
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0)
				s.push_back(CH_ZERO);
			txt = $sformatf("%0d", cnt);
			for (int i = 0; i < txt.len(); i++)
				s.push_back(txt[i]);
			s.push_back($urandom_range(0, 9) == 0 ? non_digit() : op_letter());
		end
		if (kind == 2)
			s.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		return s;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = idle_en ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch <= c;
		chars_if.last <= fin;
		do @(posedge clk); while (!chars_if.ready);
		cigar_sb.note_char(c, fin);
		sent_items++;
	endtask

	task automatic send_string(input char_q_t s);
		foreach (s[i])
			send_char(s[i], i == s.size() - 1);
	endtask

	task automatic run_random(input int n_items);
		int stop;
		stop = sent_items + n_items;
		while (sent_items < stop)
			send_string(random_cigar());
	endtask

	// drop valid, let all results drain, then cover the pipeline latency
	task automatic wait_idle();
		chars_if.valid <= 1'b0;
		while (cigar_sb.pending_entries.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max(input logic [7:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		cigar_sb.max_entries = v;
	endtask

	// result side
	initial begin
		ctp_res_t got;
		int stall;
		ent_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				ent_if.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = idle_en ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				ent_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			ent_if.ready <= 1'b1;
			do @(posedge clk); while (!(ent_if.valid && ent_if.ready));
			got.has_entry = ent_if.has_entry;
			got.op_count = ent_if.op_count;
			got.op_type = ent_if.op_type;
			got.entry_index = ent_if.entry_index;
			got.done_res = ent_if.done_res;
			got.total_entries = ent_if.total_entries;
			cigar_sb.check_result(got);
		end
	end

	initial begin
		char_q_t long_s;
		cigar_sb = new();
		hold_cycles = 0;
		idle_en = 1'b0;
		sent_items = 0;
		arst_n <= 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.ch <= '0;
		chars_if.last <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_max(8'd255);
		idle_en = 1'b1;
		// string of one non-digit, no entries; zero run dropped; op chars just outside the digit range
		send_string('{8'h00});
		send_string('{CH_ZERO, "M", "2", "5", "=", "3", "/", "4", ":"});
		// count wraps to zero and is dropped; 0xFF as op; string ends on a digit
		send_string('{"2", "5", "6", "D", "9", "9", "S", "7", 8'hFF, "5"});
		wait_idle();

		// receiver holds off while chars keep coming
		hold_cycles = 300;
		idle_en = 1'b0;
		run_random(400);
		wait_idle();

		// one string long enough to hit the 255-entry limit
		idle_en = 1'b1;
		repeat (260) begin
			long_s.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
			long_s.push_back(op_letter());
		end
		send_string(long_s);
		wait_idle();

		write_max(8'd1);
		send_string('{"3", "M", "4", "I"});
		run_random(200);
		wait_idle();

		write_max(8'd0);
		idle_en = 1'b0;
		run_random(150);
		wait_idle();

		write_max(8'($urandom_range(2, 6)));
		idle_en = 1'b1;
		run_random(300);
		wait_idle();

		write_max(8'd255);
		idle_en = 1'($urandom_range(0, 1));
		run_random(200);
		wait_idle();

		if (cigar_sb.errors == 0 && cigar_sb.pending_entries.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
src/ctp_pkg.sv
src/ctp_if.sv
src/ctp_step.sv
src/cigar_text_parser.sv
tb/tb.sv
